@@ hw/rtl/nca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_pkg
// Shared widths, codes and transaction types of the nearest-centroid L1 block.
// ----------------------------------------------------------------------------
package nca_pkg;

  localparam int NUM_CENTROIDS = 16;
  localparam int ROW_LENGTH    = 4096;

  localparam int IDX_W  = 4;
  localparam int COL_W  = 12;
  localparam int VAL_W  = 16;
  localparam int SUM_W  = 28;
  localparam int ROWS_W = 5;

  localparam int FIFO_DEPTH  = 32;
  localparam int FIFO_PTR_W  = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [ROWS_W-1:0] rows_t;

  typedef struct packed {
    logic vld;
    logic kind;
    idx_t row;
    col_t col;
    val_t val;
    logic last;
  } item_t;

  typedef struct packed {
    logic vld;
    logic have;
    idx_t idx;
    sum_t min_dist;
    logic tie;
  } tok_t;

  typedef struct packed {
    idx_t idx;
    sum_t min_dist;
    logic tie;
  } res_t;

endpackage

@@ hw/rtl/nearest_centroid_l1_assign.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_l1_assign
// Nearest-centroid search under the L1 distance over a chain of row cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a transaction with in_kind load writes
// one element of centroid row in_centroid_index at in_column; a sample
// transaction adds |value - centroid| to the sum of every row. A sample with
// in_last set closes the row and yields one result transaction on the output
// channel (out_valid / out_stall): nearest index, its distance, tie flag.
// Configuration (cfg_valid / cfg_ready, always ready) sets centroids_used;
// write it only while the block is idle.
// Throughput: one transaction per cycle while in_stall is low. Each cell reads
// its row memory once per cycle and hands the element to the next cell; the
// minimum token follows three stages behind. A 32-entry result queue
// decouples the output; in_stall rises only when 32 results are queued or in
// flight, so a stalled receiver stops the input after that many outstanding
// rows. Reset clears all sums, valid flags and the queue; centroids_used
// returns to 16. Centroid memories are not cleared and must be loaded before
// use.
// ----------------------------------------------------------------------------
module nearest_centroid_l1_assign (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  nca_pkg::idx_t         in_centroid_index,
  input  nca_pkg::col_t         in_column,
  input  nca_pkg::val_t         in_element_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output nca_pkg::idx_t         out_nearest_index,
  output nca_pkg::sum_t         out_min_distance,
  output logic                  out_tie_seen,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  nca_pkg::rows_t        cfg_data
);
  import nca_pkg::*;

  rows_t               cfg_r;
  rows_t               rows_used;
  logic [FIFO_PTR_W:0] cred_r;
  logic                in_acc;
  logic                out_acc;
  logic                cred_inc;
  item_t               item_chain [NUM_CENTROIDS+1];
  tok_t                tok_chain  [NUM_CENTROIDS+1];
  res_t                res_wr;
  res_t                res_rd;

  assign cfg_ready = 1'b1;
  assign in_stall  = cred_r == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign cred_inc  = in_acc && in_kind == KIND_SAMPLE && in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= ROWS_W'(NUM_CENTROIDS);
      cred_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      if (cred_inc && !out_acc) begin
        cred_r <= cred_r + 1'b1;
      end else if (!cred_inc && out_acc) begin
        cred_r <= cred_r - 1'b1;
      end
    end
  end

  always_comb begin
    rows_used = cfg_r;
    if (cfg_r == '0) begin
      rows_used = ROWS_W'(1);
    end else if (cfg_r > ROWS_W'(NUM_CENTROIDS)) begin
      rows_used = ROWS_W'(NUM_CENTROIDS);
    end
  end

  always_comb begin
    item_chain[0].vld  = in_acc;
    item_chain[0].kind = in_kind;
    item_chain[0].row  = in_centroid_index;
    item_chain[0].col  = in_column;
    item_chain[0].val  = in_element_value;
    item_chain[0].last = in_last;
    tok_chain[0]       = '0;
  end

  for (genvar g = 0; g < NUM_CENTROIDS; g++) begin : g_cell
    nca_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .rows_used (rows_used),
      .item_in   (item_chain[g]),
      .item_out  (item_chain[g+1]),
      .tok_in    (tok_chain[g]),
      .tok_out   (tok_chain[g+1])
    );
  end

  always_comb begin
    res_wr.idx      = tok_chain[NUM_CENTROIDS].idx;
    res_wr.min_dist = tok_chain[NUM_CENTROIDS].min_dist;
    res_wr.tie      = tok_chain[NUM_CENTROIDS].tie;
  end

  nca_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tok_chain[NUM_CENTROIDS].vld),
    .wr_data  (res_wr),
    .rd_valid (out_valid),
    .rd_en    (out_acc),
    .rd_data  (res_rd)
  );

  assign out_nearest_index = res_rd.idx;
  assign out_min_distance  = res_rd.min_dist;
  assign out_tie_seen      = res_rd.tie;

endmodule

@@ hw/rtl/nca_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_cell
// One centroid row: its element memory, its running L1 sum, and one step of
// the minimum search that travels down the chain.
// ----------------------------------------------------------------------------
module nca_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  nca_pkg::idx_t  cell_idx,
  input  nca_pkg::rows_t rows_used,
  input  nca_pkg::item_t item_in,
  output nca_pkg::item_t item_out,
  input  nca_pkg::tok_t  tok_in,
  output nca_pkg::tok_t  tok_out
);
  import nca_pkg::*;

  val_t        mem [ROW_LENGTH];
  item_t       s1_r;
  logic        s2_vld_r;
  logic        s2_last_r;
  val_t        s2_val_r;
  val_t        rd_r;
  sum_t        sum_r;
  sum_t        sum_nxt;
  logic        fin_vld_r;
  sum_t        fin_sum_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  val_t        diff;
  logic [SUM_W:0] acc;
  sum_t        sat_sum;
  logic        joins;

  always_ff @(posedge clk) begin
    if (s1_r.vld && s1_r.kind == KIND_LOAD && s1_r.row == cell_idx) begin
      mem[s1_r.col] <= s1_r.val;
    end
    if (s1_r.vld && s1_r.kind == KIND_SAMPLE) begin
      rd_r <= mem[s1_r.col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld  <= 1'b0;
      s2_vld_r  <= 1'b0;
      fin_vld_r <= 1'b0;
      tok_r.vld <= 1'b0;
      sum_r     <= '0;
    end else begin
      s1_r      <= item_in;
      s2_vld_r  <= s1_r.vld && s1_r.kind == KIND_SAMPLE;
      fin_vld_r <= s2_vld_r && s2_last_r;
      tok_r     <= tok_nxt;
      sum_r     <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_val_r  <= s1_r.val;
    s2_last_r <= s1_r.last;
    fin_sum_r <= sat_sum;
  end

  always_comb begin
    diff    = (s2_val_r >= rd_r) ? (s2_val_r - rd_r) : (rd_r - s2_val_r);
    acc     = {1'b0, sum_r} + (SUM_W + 1)'(diff);
    sat_sum = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
    sum_nxt = sum_r;
    if (s2_vld_r) begin
      sum_nxt = s2_last_r ? '0 : sat_sum;
    end
  end

  always_comb begin
    joins   = {1'b0, cell_idx} < rows_used;
    tok_nxt = tok_in;
    if (joins) begin
      if (!tok_in.have || fin_sum_r < tok_in.min_dist) begin
        tok_nxt.have     = 1'b1;
        tok_nxt.idx      = cell_idx;
        tok_nxt.min_dist = fin_sum_r;
        tok_nxt.tie      = 1'b0;
      end else if (fin_sum_r == tok_in.min_dist) begin
        tok_nxt.tie = 1'b1;
      end
    end
    tok_nxt.vld = fin_vld_r;
  end

  assign item_out = s1_r;
  assign tok_out  = tok_r;

endmodule

@@ hw/rtl/nca_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_out_fifo
// Result queue between the cell chain and the output channel.
// ----------------------------------------------------------------------------
module nca_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  nca_pkg::res_t wr_data,
  output logic          rd_valid,
  input  logic          rd_en,
  output nca_pkg::res_t rd_data
);
  import nca_pkg::*;

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W:0]   cnt_r;
  logic [FIFO_PTR_W:0]   cnt_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rd_ptr_r];

endmodule

@@ sim/l1_search_board_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l1_search_board_pkg
// Scoreboard for the nearest-centroid L1 block. It mirrors the centroid
// memories, the per-row distance sums and the row count, predicts the
// placement of each closed sample row and checks the results in order.
// ----------------------------------------------------------------------------
package l1_search_board_pkg;

  import nca_pkg::*;

  typedef struct packed {
    idx_t nearest;
    sum_t distance;
    logic tie;
  } placement_t;

  class l1_search_board;
    val_t       centroid_mem [NUM_CENTROIDS][ROW_LENGTH];
    bit         loaded [NUM_CENTROIDS][ROW_LENGTH];
    sum_t       row_sums [NUM_CENTROIDS];
    rows_t      rows_cfg;
    col_t       ready_cols[$];
    placement_t pending_results[$];
    int         mismatches;
    int         checked;
    int         tied;
    int         saturated;

    function new();
      rows_cfg = rows_t'(NUM_CENTROIDS);
      foreach (row_sums[k]) row_sums[k] = '0;
      mismatches = 0;
      checked = 0;
      tied = 0;
      saturated = 0;
    endfunction

    function void set_rows(rows_t value);
      rows_cfg = value;
    endfunction

    function void note_item(logic kind, idx_t row, col_t col, val_t value, logic last);
      val_t         diff;
      logic [SUM_W:0] acc;
      placement_t   place;
      int           used;
      bit           complete;
      if (kind == KIND_LOAD) begin
        if (!loaded[row][col]) begin
          loaded[row][col] = 1'b1;
          complete = 1'b1;
          for (int k = 0; k < NUM_CENTROIDS; k++) begin
            if (!loaded[k][col]) complete = 1'b0;
          end
          if (complete) ready_cols.push_back(col);
        end
        centroid_mem[row][col] = value;
        return;
      end
      for (int k = 0; k < NUM_CENTROIDS; k++) begin
        diff = (value >= centroid_mem[k][col]) ? value - centroid_mem[k][col]
                                               : centroid_mem[k][col] - value;
        acc = {1'b0, row_sums[k]} + diff;
        row_sums[k] = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
      end
      if (!last) return;
      used = rows_cfg;
      if (used < 1) used = 1;
      if (used > NUM_CENTROIDS) used = NUM_CENTROIDS;
      place.nearest = '0;
      place.distance = row_sums[0];
      place.tie = 1'b0;
      for (int k = 1; k < used; k++) begin
        if (row_sums[k] < place.distance) begin
          place.nearest = idx_t'(k);
          place.distance = row_sums[k];
          place.tie = 1'b0;
        end else if (row_sums[k] == place.distance) begin
          place.tie = 1'b1;
        end
      end
      pending_results.push_back(place);
      foreach (row_sums[k]) row_sums[k] = '0;
    endfunction

    function void check_result(idx_t nearest, sum_t distance, logic tie);
      placement_t want;
      checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: nearest_index %0d min_distance %0d tie_seen %0d",
               nearest, distance, tie);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (nearest !== want.nearest) begin
        $error("nearest_index: expected %0d, got %0d", want.nearest, nearest);
        mismatches++;
      end
      if (distance !== want.distance) begin
        $error("min_distance: expected %0d, got %0d", want.distance, distance);
        mismatches++;
      end
      if (tie !== want.tie) begin
        $error("tie_seen: expected %0d, got %0d", want.tie, tie);
        mismatches++;
      end
      if (want.tie) tied++;
      if (want.distance == SUM_MAX) saturated++;
    endfunction
  endclass

endpackage

@@ sim/nearest_centroid_l1_assign_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_l1_assign_test
// Self-checking bench for the nearest-centroid L1 block. It loads a centroid
// table, runs directed rows for ties, extremes and row-count clamping, then
// random phases with random row counts, random gaps on both sides and one
// long output hold that backs the block up to its input.
// ----------------------------------------------------------------------------
module nearest_centroid_l1_assign_test;

  import nca_pkg::*;
  import l1_search_board_pkg::*;

  localparam int RANDOM_ITEMS  = 760;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 1500;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  in_kind = KIND_LOAD;
  idx_t  in_centroid_index = '0;
  col_t  in_column = '0;
  val_t  in_element_value = '0;
  logic  in_last = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  idx_t  out_nearest_index;
  sum_t  out_min_distance;
  logic  out_tie_seen;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  rows_t cfg_data = '0;

  l1_search_board board;
  int in_gap_max = 0;
  int out_gap_max = 0;
  bit long_hold_req = 1'b0;
  int items_sent = 0;
  int cfg_writes = 0;
  int wait_left = 0;
  int hold_left = 0;
  int gap_choices[3] = '{0, 3, 13};

  always #10 clk = ~clk;

  nearest_centroid_l1_assign dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_centroid_index (in_centroid_index),
    .in_column         (in_column),
    .in_element_value  (in_element_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nearest_index (out_nearest_index),
    .out_min_distance  (out_min_distance),
    .out_tie_seen      (out_tie_seen),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  function automatic val_t draw_value();
    val_t value;
    case ($urandom_range(0, 3))
      0: value = val_t'($urandom);
      1: value = val_t'($urandom_range(0, 4) * 8192);
      2: value = val_t'($urandom_range(0, 32768));
      default: value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endcase
    return value;
  endfunction

  task automatic send_item(logic kind, idx_t row, col_t col, val_t value, logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_centroid_index <= row;
    in_column <= col;
    in_element_value <= value;
    in_last <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_item(kind, row, col, value, last);
    items_sent++;
  endtask

  task automatic send_row(int len);
    col_t col;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 3) == 0) col = col_t'($urandom);
        else col = board.ready_cols[$urandom_range(0, board.ready_cols.size() - 1)];
        send_item(KIND_LOAD, idx_t'($urandom), col, draw_value(), logic'($urandom_range(0, 1)));
      end
      col = board.ready_cols[$urandom_range(0, board.ready_cols.size() - 1)];
      send_item(KIND_SAMPLE, idx_t'($urandom), col, draw_value(), i == len - 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rows(rows_t value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    board.set_rows(value);
    cfg_writes++;
  endtask

  initial begin : drain
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        board.check_result(out_nearest_index, out_min_distance, out_tie_seen);
        wait_left = $urandom_range(0, out_gap_max);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      out_stall <= (hold_left > 0) || (wait_left > 0);
      if (hold_left > 0) hold_left--;
      else if (wait_left > 0) wait_left--;
    end
  end

  initial begin : stimulus
    col_t  setup_cols[$];
    val_t  entry_value;
    rows_t cfg_pick;
    int    random_start;
    int    phase;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_rows(rows_t'(NUM_CENTROIDS));
    in_gap_max = 13;
    out_gap_max = 13;

    setup_cols = '{12'd0, 12'd1, 12'd2, 12'd4095, 12'hAAA, 12'h555};
    repeat (10) setup_cols.push_back(col_t'($urandom));
    foreach (setup_cols[c]) begin
      for (int k = 0; k < NUM_CENTROIDS; k++) begin
        case (c)
          0: entry_value = '0;
          1: entry_value = val_t'(5000 + k * 1000);
          2: entry_value = val_t'(((k > 7) ? k - 7 : 7 - k) * 1000);
          3: entry_value = val_t'(65535 - k);
          default: entry_value = draw_value();
        endcase
        send_item(KIND_LOAD, idx_t'(k), setup_cols[c], entry_value, 1'b0);
      end
    end

    send_item(KIND_SAMPLE, 4'hF, 12'd0, 16'd0, 1'b1);
    send_item(KIND_SAMPLE, 4'h0, 12'd4095, 16'hFFFF, 1'b1);
    send_item(KIND_SAMPLE, 4'h0, 12'd1, 16'd0, 1'b1);
    send_item(KIND_SAMPLE, 4'h0, 12'd1, 16'hFFFF, 1'b1);
    send_item(KIND_SAMPLE, 4'h0, 12'd1, 16'd12000, 1'b1);
    send_item(KIND_SAMPLE, 4'h0, 12'd2, 16'd1000, 1'b1);
    send_item(KIND_SAMPLE, 4'h0, 12'd2, 16'd40000, 1'b0);
    send_item(KIND_SAMPLE, 4'h0, 12'd1, 16'd32769, 1'b1);
    send_item(KIND_LOAD, 4'd5, 12'd1, 16'd10000, 1'b1);
    send_item(KIND_SAMPLE, 4'h0, 12'd1, 16'd10000, 1'b1);
    write_rows(rows_t'(1));
    send_item(KIND_SAMPLE, 4'h0, 12'd0, 16'd7, 1'b1);
    send_item(KIND_SAMPLE, 4'h0, 12'd2, 16'd1000, 1'b1);
    write_rows(rows_t'(0));
    send_item(KIND_SAMPLE, 4'h0, 12'd1, 16'hFFFF, 1'b1);
    write_rows(rows_t'(31));
    send_item(KIND_SAMPLE, 4'h0, 12'd2, 16'd1000, 1'b1);
    write_rows(rows_t'(17));
    send_item(KIND_SAMPLE, 4'h0, 12'd1, 16'd0, 1'b1);
    write_rows(rows_t'(NUM_CENTROIDS));

    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: cfg_pick = rows_t'(0);
        1: cfg_pick = rows_t'(1);
        2: cfg_pick = rows_t'(NUM_CENTROIDS);
        3: cfg_pick = rows_t'(31);
        default: cfg_pick = rows_t'($urandom_range(0, 31));
      endcase
      write_rows(cfg_pick);
      in_gap_max = gap_choices[$urandom_range(0, 2)];
      out_gap_max = gap_choices[$urandom_range(0, 2)];
      if (phase == 0) begin
        in_gap_max = 0;
        long_hold_req = 1'b1;
        repeat (60) send_row(1);
      end else begin
        repeat ($urandom_range(5, 20)) begin
          send_row(($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(1, 6));
        end
      end
      phase++;
    end
    settle();

    $display("run covered %0d input transactions and %0d results, %0d tied, %0d saturated",
             items_sent, board.checked, board.tied, board.saturated);
    $display("centroids_used written %0d times across %0d random phases", cfg_writes, phase);
    if (board.mismatches == 0) begin
      $display("nearest_centroid_l1_assign: match");
    end else begin
      $display("nearest_centroid_l1_assign: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("nearest_centroid_l1_assign: mismatch");
    $finish;
  end

endmodule
